>>> src/assert_macros.svh
// Assertion macros used by the top level of the idle watchdog.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define IWMH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition that must never be true outside reset.
`define IWMH_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define IWMH_ASSERT(label, clk, rst, prop)
`define IWMH_NEVER(label, clk, rst, cond)
`endif
`endif

>>> src/iwmh_pkg.sv
// Package of the idle watchdog: field widths, register indexes, status codes
// and the activity summary struct. Depends on nothing.
`default_nettype none

package iwmh_pkg;

   localparam int unsigned COORD_W   = 16;
   localparam int unsigned MASK_W    = 13;
   localparam int unsigned KEYS_W    = 256;
   localparam int unsigned TICKS_W   = 20;
   localparam int unsigned THRESH_W  = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 304;
   localparam int unsigned RSP_DATA_W = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAIT_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd2;

   // Reset values of the registers.
   localparam logic [TICKS_W-1:0]  TIMEOUT_RESET   = 20'd600;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd10;

   typedef enum logic [1:0] {
      STATUS_COUNTING = 2'd0,
      STATUS_IDLE     = 2'd1,
      STATUS_ACTIVE   = 2'd2
   } status_type;

   // What one sample shows, passed from the activity detector to the top.
   typedef struct packed {
      logic pointer_active;
      logic key_active;
      logic record_pos;
   } activity_type;

endpackage

`default_nettype wire

>>> src/iwmh_activity.sv
// Activity detector of the idle watchdog: key map OR-reduce, button mask test
// and Manhattan pointer motion against the threshold. Uses iwmh_pkg.
`default_nettype none

module iwmh_activity (
   input  wire logic                                 pointer_found,
   input  wire logic signed [iwmh_pkg::COORD_W-1:0]  pointer_x,
   input  wire logic signed [iwmh_pkg::COORD_W-1:0]  pointer_y,
   input  wire logic        [iwmh_pkg::MASK_W-1:0]   button_mask,
   input  wire logic        [iwmh_pkg::KEYS_W-1:0]   keys,
   input  wire logic signed [iwmh_pkg::COORD_W-1:0]  last_x,
   input  wire logic signed [iwmh_pkg::COORD_W-1:0]  last_y,
   input  wire logic                                 position_known,
   input  wire logic        [iwmh_pkg::THRESH_W-1:0] move_threshold,
   output iwmh_pkg::activity_type                    activity
);

   logic signed [iwmh_pkg::COORD_W:0] diff_x;
   logic signed [iwmh_pkg::COORD_W:0] diff_y;
   logic        [iwmh_pkg::COORD_W:0] mag_x;
   logic        [iwmh_pkg::COORD_W:0] mag_y;
   logic        [iwmh_pkg::COORD_W:0] distance;
   logic                              moved;

   // Differences are taken one bit wider so they cannot overflow; each
   // magnitude then fits in the coordinate width.
   assign diff_x = {pointer_x[iwmh_pkg::COORD_W-1], pointer_x}
                 - {last_x[iwmh_pkg::COORD_W-1], last_x};
   assign diff_y = {pointer_y[iwmh_pkg::COORD_W-1], pointer_y}
                 - {last_y[iwmh_pkg::COORD_W-1], last_y};
   assign mag_x  = diff_x[iwmh_pkg::COORD_W] ? -diff_x : diff_x;
   assign mag_y  = diff_y[iwmh_pkg::COORD_W] ? -diff_y : diff_y;

   assign distance = {1'b0, mag_x[iwmh_pkg::COORD_W-1:0]}
                   + {1'b0, mag_y[iwmh_pkg::COORD_W-1:0]};
   assign moved    = distance > {1'b0, move_threshold};

   always_comb begin
      activity.key_active     = |keys;
      activity.pointer_active = pointer_found && position_known
                                && ((|button_mask) || moved);
      activity.record_pos     = pointer_found
                                && (!position_known || activity.pointer_active);
   end

endmodule

`default_nettype wire

>>> src/idle_watchdog_motion_hysteresis.sv
// Top level of the idle watchdog with pointer-motion hysteresis.
// Depends on iwmh_pkg, iwmh_activity and assert_macros.svh.
//
// Usage: every sample tick is one item on the req_ stream. The item carries
// the pointer position, the button and modifier mask and a 256-bit key map;
// req_tuser says whether the pointer was read on this tick. For each item the
// block returns exactly one item on the rsp_ stream: rsp_tuser holds the
// status (still counting, idle reached, activity ended the run) and
// rsp_tdata the quiet ticks left after this sample.
// The result of an item accepted at one edge is registered and shown from that
// edge on. Throughput is one item per cycle while the receiver keeps up; the
// activity test and the countdown update are a single pass of logic before the
// result register. When the receiver stalls the result register holds its item
// and req_tready stays high only if that item is taken in the same cycle, so no
// result is lost. Configuration writes on the csr_ port are always ready; a new
// timeout acts at the next load or reload, mode and threshold on the next item.
// Reset clears the countdown, the armed flag and the recorded position, and
// restores the registers to 600 ticks, report mode and a threshold of 10.
`default_nettype none
`include "assert_macros.svh"

module idle_watchdog_motion_hysteresis (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input stream.
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   // tdata, from bit 0 up: pointer_x[15:0], pointer_y[31:16],
   // button_mask[44:32], keys_word0[108:45], keys_word1[172:109],
   // keys_word2[236:173], keys_word3[300:237], zero fill[303:301].
   input  wire logic [iwmh_pkg::REQ_DATA_W-1:0]       req_tdata,
   // tuser: pointer_found[0].
   input  wire logic                                  req_tuser,
   // Result stream.
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // tdata, from bit 0 up: ticks_left[19:0], zero fill[23:20].
   output      logic [iwmh_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tuser: status[1:0].
   output      logic [1:0]                            rsp_tuser,
   // Configuration write channel.
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [iwmh_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [iwmh_pkg::TICKS_W-1:0]          csr_data
);

   localparam int unsigned COORD_W = iwmh_pkg::COORD_W;
   localparam int unsigned TICKS_W = iwmh_pkg::TICKS_W;

   // Configuration registers.
   logic [TICKS_W-1:0]            timeout_ff;
   logic                          wait_mode_ff;
   logic [iwmh_pkg::THRESH_W-1:0] threshold_ff;

   // Watchdog state.
   logic [TICKS_W-1:0]            remaining_ff, remaining_in;
   logic                          armed_ff, armed_in;
   logic signed [COORD_W-1:0]     last_x_ff, last_x_in;
   logic signed [COORD_W-1:0]     last_y_ff, last_y_in;
   logic                          position_known_ff, position_known_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [TICKS_W-1:0]            rsp_ticks_ff, rsp_ticks_in;
   iwmh_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                          req_accept;
   logic                          active;
   logic [TICKS_W-1:0]            start_count;
   logic [TICKS_W-1:0]            count_dec;
   iwmh_pkg::activity_type        activity;

   logic signed [COORD_W-1:0]     in_x;
   logic signed [COORD_W-1:0]     in_y;

   assign in_x = req_tdata[15:0];
   assign in_y = req_tdata[31:16];

   iwmh_activity u_activity (
      .pointer_found  (req_tuser),
      .pointer_x      (in_x),
      .pointer_y      (in_y),
      .button_mask    (req_tdata[44:32]),
      .keys           (req_tdata[300:45]),
      .last_x         (last_x_ff),
      .last_y         (last_y_ff),
      .position_known (position_known_ff),
      .move_threshold (threshold_ff),
      .activity       (activity)
   );

   // A new item may enter whenever the result register is empty or its item
   // leaves in this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign active      = activity.pointer_active || activity.key_active;
   // An unarmed watchdog loads the full period on this tick.
   assign start_count = armed_ff ? remaining_ff : timeout_ff;
   assign count_dec   = start_count - 1'b1;

   always_comb begin
      remaining_in      = remaining_ff;
      armed_in          = armed_ff;
      last_x_in         = last_x_ff;
      last_y_in         = last_y_ff;
      position_known_in = position_known_ff;
      rsp_ticks_in      = rsp_ticks_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;

      if (req_accept) begin
         rsp_valid_in = 1'b1;
         armed_in     = 1'b1;
         if (activity.record_pos) begin
            last_x_in         = in_x;
            last_y_in         = in_y;
            position_known_in = 1'b1;
         end

         if (active) begin
            if (wait_mode_ff) begin
               // Activity restarts the full quiet period.
               remaining_in  = timeout_ff;
               rsp_status_in = iwmh_pkg::STATUS_COUNTING;
            end else begin
               // Activity ends the run with the count left undecremented.
               remaining_in  = start_count;
               rsp_status_in = iwmh_pkg::STATUS_ACTIVE;
               armed_in      = 1'b0;
            end
         end else if (start_count != '0) begin
            remaining_in  = count_dec;
            rsp_status_in = iwmh_pkg::STATUS_COUNTING;
            if (count_dec == '0) begin
               rsp_status_in = iwmh_pkg::STATUS_IDLE;
               armed_in      = 1'b0;
            end
         end else begin
            // A zero period never expires.
            remaining_in  = start_count;
            rsp_status_in = iwmh_pkg::STATUS_COUNTING;
         end
         rsp_ticks_in = remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff        <= iwmh_pkg::TIMEOUT_RESET;
         wait_mode_ff      <= 1'b0;
         threshold_ff      <= iwmh_pkg::THRESHOLD_RESET;
         remaining_ff      <= '0;
         armed_ff          <= 1'b0;
         last_x_ff         <= '0;
         last_y_ff         <= '0;
         position_known_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         remaining_ff      <= remaining_in;
         armed_ff          <= armed_in;
         last_x_ff         <= last_x_in;
         last_y_ff         <= last_y_in;
         position_known_ff <= position_known_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               iwmh_pkg::REG_TIMEOUT_TICKS:  timeout_ff   <= csr_data;
               iwmh_pkg::REG_WAIT_MODE:      wait_mode_ff <= csr_data[0];
               iwmh_pkg::REG_MOVE_THRESHOLD: threshold_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_ticks_ff  <= rsp_ticks_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(iwmh_pkg::RSP_DATA_W - TICKS_W){1'b0}}, rsp_ticks_ff};
   assign rsp_tuser  = rsp_status_ff;

   // An idle report always comes with an empty countdown.
   `IWMH_ASSERT(a_idle_zero, clock, reset,
      (rsp_tvalid && rsp_tuser == iwmh_pkg::STATUS_IDLE) |-> (rsp_tdata[19:0] == '0))
   // Any reported end leaves the watchdog unarmed for the next tick.
   `IWMH_ASSERT(a_end_disarms, clock, reset,
      (req_accept && rsp_status_in != iwmh_pkg::STATUS_COUNTING) |=> !armed_ff)
   // In wait mode activity never ends a run.
   `IWMH_NEVER(a_wait_no_end, clock, reset,
      req_accept && wait_mode_ff && rsp_status_in == iwmh_pkg::STATUS_ACTIVE)
   // Once a position is recorded it stays known until reset.
   `IWMH_ASSERT(a_pos_sticky, clock, reset, position_known_ff |=> position_known_ff)

endmodule

`default_nettype wire

>>> tb/tb_idle_watchdog_motion_hysteresis.sv
`timescale 1ns / 100ps
// Self-checking testbench of the idle watchdog with pointer-motion hysteresis.
// Depends on iwmh_pkg and the idle_watchdog_motion_hysteresis RTL; a scoreboard
// class predicts each tick's status and remaining count and checks the results.

module tb_idle_watchdog_motion_hysteresis;

   localparam int unsigned COORD_W    = iwmh_pkg::COORD_W;
   localparam int unsigned MASK_W     = iwmh_pkg::MASK_W;
   localparam int unsigned KEYS_W     = iwmh_pkg::KEYS_W;
   localparam int unsigned TICKS_W    = iwmh_pkg::TICKS_W;
   localparam int unsigned THRESH_W   = iwmh_pkg::THRESH_W;
   localparam int unsigned CSR_IDX_W  = iwmh_pkg::CSR_IDX_W;
   localparam int unsigned REQ_DATA_W = iwmh_pkg::REQ_DATA_W;
   localparam int unsigned RSP_DATA_W = iwmh_pkg::RSP_DATA_W;

   // Cycles of the long receiver hold-off that fills the block and stalls input.
   localparam int unsigned HOLD_CYCLES = 40;
   // Sample items per random configuration phase, and the number of phases.
   localparam int unsigned PHASE_ITEMS = 85;
   localparam int unsigned PHASES      = 12;
   // Hard stop for the whole run, in ns; far above the slowest correct run.
   localparam int unsigned RUN_LIMIT_NS = 1_000_000;
   localparam logic [TICKS_W-1:0] TIMEOUT_MAX = 20'd999_990;
   // A register index past the end of the register list.
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 2'd3;

   // One expected result item: the status code and the quiet ticks left.
   typedef struct {
      iwmh_pkg::status_type status;
      logic [TICKS_W-1:0]   ticks_left;
   } tick_outcome_type;

   // One sample tick as offered on the input stream.
   typedef struct {
      bit                         found;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic [MASK_W-1:0]          mask;
      logic [KEYS_W-1:0]          keys;
   } sample_type;

   // The scoreboard keeps its own copy of the registers and of the watchdog
   // state, works out the outcome of every accepted sample and checks the
   // result items against those outcomes in order.
   class watchdog_scoreboard;
      logic [TICKS_W-1:0]        timeout_ticks;
      bit                        wait_mode;
      logic [THRESH_W-1:0]       move_threshold;
      logic [TICKS_W-1:0]        remaining;
      bit                        armed;
      logic signed [COORD_W-1:0] last_x;
      logic signed [COORD_W-1:0] last_y;
      bit                        position_known;
      tick_outcome_type          outcome_q[$];
      int unsigned               failures;
      int unsigned               checked;
      int unsigned               idle_seen;
      int unsigned               active_seen;

      function new();
         timeout_ticks  = iwmh_pkg::TIMEOUT_RESET;
         wait_mode      = 1'b0;
         move_threshold = iwmh_pkg::THRESHOLD_RESET;
         remaining      = '0;
         armed          = 1'b0;
         last_x         = '0;
         last_y         = '0;
         position_known = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [TICKS_W-1:0] value);
         case (idx)
            iwmh_pkg::REG_TIMEOUT_TICKS:  timeout_ticks  = value;
            iwmh_pkg::REG_WAIT_MODE:      wait_mode      = value[0];
            iwmh_pkg::REG_MOVE_THRESHOLD: move_threshold = value[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(sample_type s);
         int               dx;
         int               dy;
         bit               pointer_moved;
         bit               keys_down;
         tick_outcome_type outcome;
         pointer_moved = 1'b0;
         if (!armed) begin
            remaining = timeout_ticks;
            armed     = 1'b1;
         end
         if (s.found) begin
            if (!position_known) begin
               position_known = 1'b1;
               last_x         = s.x;
               last_y         = s.y;
            end else begin
               dx = int'(s.x) - int'(last_x);
               dy = int'(s.y) - int'(last_y);
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               pointer_moved = (s.mask != '0) || (dx + dy > int'(move_threshold));
               if (pointer_moved) begin
                  last_x = s.x;
                  last_y = s.y;
               end
            end
         end
         keys_down      = |s.keys;
         outcome.status = iwmh_pkg::STATUS_COUNTING;
         if (pointer_moved || keys_down) begin
            if (wait_mode) begin
               remaining = timeout_ticks;
            end else begin
               outcome.status = iwmh_pkg::STATUS_ACTIVE;
               armed          = 1'b0;
            end
         end else if (remaining != '0) begin
            remaining = remaining - 1'b1;
            if (remaining == '0) begin
               outcome.status = iwmh_pkg::STATUS_IDLE;
               armed          = 1'b0;
            end
         end
         outcome.ticks_left = remaining;
         outcome_q.push_back(outcome);
      endfunction

      function void check_tick(logic [1:0] status, logic [RSP_DATA_W-1:0] data);
         tick_outcome_type want;
         if (outcome_q.size() == 0) begin
            $error("result with status %0d, ticks_left %0d arrived with none expected",
                   status, data[TICKS_W-1:0]);
            failures++;
            return;
         end
         want = outcome_q.pop_front();
         checked++;
         if (status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (data[TICKS_W-1:0] != want.ticks_left) begin
            $error("ticks_left: expected %0d, actual %0d", want.ticks_left,
                   data[TICKS_W-1:0]);
            failures++;
         end
         if (want.status == iwmh_pkg::STATUS_IDLE) idle_seen++;
         if (want.status == iwmh_pkg::STATUS_ACTIVE) active_seen++;
      endfunction

      function int unsigned outstanding();
         return outcome_q.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [TICKS_W-1:0]      csr_data;

   watchdog_scoreboard sb;

   // Knobs shared by the stimulus process and the receiver process.
   bit          send_idle_en;
   bit          recv_idle_en;
   bit          long_hold_req;
   int unsigned samples_sent;

   idle_watchdog_motion_hysteresis uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one sample item, optionally after a short idle burst, and leaves
   // tvalid high once it is taken so that back-to-back items need no toggle.
   // The scoreboard learns of the item at the very edge that accepts it.
   task automatic send_sample(sample_type s);
      int unsigned gap;
      gap = 0;
      if (send_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.found;
      req_tdata  <= {3'b000, s.keys, s.mask, s.y, s.x};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(s);
      samples_sent++;
   endtask

   // Drops tvalid and waits until every expected result has come back, so that
   // registers can be written safely.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TICKS_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic sample_type mk(bit found, int x, int y, int mask,
                                     logic [KEYS_W-1:0] keys);
      sample_type s;
      s.found = found;
      s.x     = x[COORD_W-1:0];
      s.y     = y[COORD_W-1:0];
      s.mask  = mask[MASK_W-1:0];
      s.keys  = keys;
      return s;
   endfunction

   // Random sample. With probability act_pct percent the item aims at activity
   // (keys, buttons, a move just around the threshold, or a jump anywhere);
   // otherwise it is a quiet tick with jitter that stays within the threshold.
   // Moves are taken relative to the position the scoreboard has recorded.
   function automatic sample_type random_sample(int unsigned act_pct);
      sample_type s;
      int         span;
      int         dx;
      int         dy;
      int         nx;
      int         ny;
      s.found = ($urandom_range(0, 9) != 0);
      s.mask  = '0;
      s.keys  = '0;
      nx      = int'(sb.last_x);
      ny      = int'(sb.last_y);
      span    = -1;
      if ($urandom_range(0, 99) < act_pct) begin
         case ($urandom_range(0, 4))
            0: s.keys[$urandom_range(0, KEYS_W-1)] = 1'b1;
            1: for (int i = 0; i < KEYS_W / 32; i++) s.keys[i*32 +: 32] = $urandom;
            2: s.mask = ($urandom_range(0, 1) != 0) ? MASK_W'(1 << $urandom_range(0, 12))
                                                    : MASK_W'($urandom_range(1, 8191));
            3: begin
               span = int'(sb.move_threshold) + int'($urandom_range(0, 2)) - 1;
               if (span < 0) span = 0;
            end
            default: begin
               nx = int'($urandom_range(0, 65535)) - 32768;
               ny = int'($urandom_range(0, 65535)) - 32768;
            end
         endcase
      end else begin
         span = $urandom_range(0, (sb.move_threshold < 3) ? int'(sb.move_threshold) : 3);
         // A pointer that was not read may carry any mask; it must be ignored.
         if (!s.found && $urandom_range(0, 1) != 0) s.mask = MASK_W'($urandom);
      end
      if (span >= 0) begin
         dx = $urandom_range(0, (span < 32767) ? span : 32767);
         dy = span - dx;
         if (dy > 32767) dy = 32767;
         if ($urandom_range(0, 1) != 0) dx = -dx;
         if ($urandom_range(0, 1) != 0) dy = -dy;
         nx = int'(sb.last_x) + dx;
         ny = int'(sb.last_y) + dy;
         // Bounce off the edges of the coordinate range instead of wrapping.
         if (nx > 32767 || nx < -32768) nx = int'(sb.last_x) - dx;
         if (ny > 32767 || ny < -32768) ny = int'(sb.last_y) - dy;
      end
      s.x = nx[COORD_W-1:0];
      s.y = ny[COORD_W-1:0];
      return s;
   endfunction

   // Result side: checks every accepted result item against the oldest outcome.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_tick(rsp_tuser, rsp_tdata);
   end

   // Receiver readiness. Random stall bursts when enabled, and on request one
   // long hold-off counted here while the sender keeps offering items.
   initial begin
      int unsigned burst;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (burst) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hard limit on the run time.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Run stopped by the time limit with %0d results outstanding.",
               sb.outstanding());
      $display("** idle_watchdog_motion_hysteresis: FAILED **");
      $finish;
   end

   initial begin
      int unsigned        act_pct;
      logic [TICKS_W-1:0] tmo;
      logic [TICKS_W-1:0] thr;
      sb            = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_idle_en  = 1'b0;
      recv_idle_en  = 1'b0;
      long_hold_req = 1'b0;
      samples_sent  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset registers: 600 ticks, report mode, threshold 10.
      // An unread pointer with every button bit set does not count.
      send_sample(mk(0, 32767, -32768, 8191, '0));
      // The first read only records the position, even with buttons held.
      send_sample(mk(1, 100, 100, 8191, '0));
      // A move of exactly the threshold is quiet, one more ends the run.
      send_sample(mk(1, 105, 105, 0, '0));
      send_sample(mk(1, 106, 105, 0, '0));
      // Top key bit ends the freshly loaded run with the full count left.
      send_sample(mk(0, 0, 0, 0, {1'b1, {(KEYS_W-1){1'b0}}}));
      send_sample(mk(1, 106, 105, 1, '0));
      settle();

      // Wait mode, short timeout, largest threshold.
      write_csr(iwmh_pkg::REG_TIMEOUT_TICKS, 20'd3);
      write_csr(iwmh_pkg::REG_WAIT_MODE, 20'd1);
      write_csr(iwmh_pkg::REG_MOVE_THRESHOLD, 20'd65535);
      send_sample(mk(1, 32767, 32767, 13'h1000, '0));
      // Corner to corner exceeds any threshold; a move of exactly 65535 does not.
      send_sample(mk(1, -32768, -32768, 0, '0));
      send_sample(mk(1, 32767, -32768, 0, '0));
      // Two quiet ticks more and idle is reached with zero left.
      send_sample(mk(0, 0, 0, 0, '0));
      send_sample(mk(0, 0, 0, 0, '0));
      send_sample(mk(0, 0, 0, 0, KEYS_W'(1)));
      settle();

      // Zero timeout, zero threshold: the next reload makes the count zero
      // for good, and in wait mode nothing ever ends.
      write_csr(iwmh_pkg::REG_TIMEOUT_TICKS, 20'd0);
      write_csr(iwmh_pkg::REG_MOVE_THRESHOLD, 20'd0);
      send_sample(mk(1, -32767, -32768, 0, '0));
      send_sample(mk(1, -32767, -32768, 0, '0));
      send_sample(mk(0, 0, 0, 0, {KEYS_W{1'b1}}));
      settle();
      write_csr(iwmh_pkg::REG_WAIT_MODE, 20'd0);
      send_sample(mk(1, -32767, -32768, 0, '0));
      send_sample(mk(0, 0, 0, 0, KEYS_W'(1) << 64));
      settle();

      // A timeout of one goes idle on the very tick it is loaded.
      write_csr(iwmh_pkg::REG_TIMEOUT_TICKS, 20'd1);
      send_sample(mk(0, 0, 0, 0, '0));
      send_sample(mk(1, -32767, -32768, 0, '0));
      settle();
      write_csr(iwmh_pkg::REG_TIMEOUT_TICKS, TIMEOUT_MAX);
      write_csr(iwmh_pkg::REG_WAIT_MODE, 20'd1);
      send_sample(mk(0, 0, 0, 0, KEYS_W'(1) << 128));
      send_sample(mk(1, -32767, -32768, 0, '0));
      settle();

      // Random part: each phase picks a configuration, an activity level and
      // idling on either side. Short timeouts dominate so idle reports are
      // frequent; one phase holds off the receiver for a long stretch, and
      // the last phases run at full rate with no idling at all.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       tmo = '0;
            1:       tmo = TIMEOUT_MAX;
            2:       tmo = 20'd1;
            default: tmo = TICKS_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = 20'd65535;
            2:       thr = TICKS_W'($urandom_range(0, 65535));
            default: thr = TICKS_W'($urandom_range(0, 40));
         endcase
         write_csr(iwmh_pkg::REG_TIMEOUT_TICKS, tmo);
         write_csr(iwmh_pkg::REG_WAIT_MODE, TICKS_W'($urandom_range(0, 1)));
         write_csr(iwmh_pkg::REG_MOVE_THRESHOLD, thr);
         // An index past the register list must leave every register alone.
         if (phase == 4) write_csr(REG_NONE, TICKS_W'($urandom));
         send_idle_en = (phase < PHASES - 2) && ($urandom_range(0, 2) != 0);
         recv_idle_en = (phase < PHASES - 2) && ($urandom_range(0, 2) != 0);
         if (phase == 3) long_hold_req = 1'b1;
         act_pct = $urandom_range(2, 35);
         repeat (PHASE_ITEMS) send_sample(random_sample(act_pct));
         settle();
      end

      repeat (4) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d expected results never arrived", sb.outstanding());
         sb.failures++;
      end
      $display("Sent %0d samples over %0d register settings; checked %0d results.",
               samples_sent, PHASES + 6, sb.checked);
      $display("Seen %0d idle reports and %0d activity reports.",
               sb.idle_seen, sb.active_seen);
      if (sb.failures == 0) begin
         $display("** idle_watchdog_motion_hysteresis: PASSED **");
      end else begin
         $display("** idle_watchdog_motion_hysteresis: FAILED **");
      end
      $finish;
   end

endmodule
